@@ sv/crc8fu_pkg.sv @@
// Package for the CRC-8 frame unpacker: item types, constants and the CRC byte update.
`default_nettype none

package crc8fu_pkg;

	// CRC-8 generator polynomial (x^8 + x^2 + x + 1) and start value.
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;

	// One received byte and its frame marker.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_item_t;

	// One decoded frame.
	typedef struct packed {
		logic [7:0]  device_address;
		logic [7:0]  opcode;
		logic [7:0]  payload_length;
		logic [15:0] payload_value;
		logic        crc_ok;
		logic [7:0]  computed_crc;
	} out_item_t;

	// Frame event passed from the parser to the output stage.
	typedef struct packed {
		logic      fire;
		out_item_t res;
	} frame_evt_t;

	// Advance the CRC by one byte, most significant bit first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/crc8fu_if.sv @@
// Valid/ready channel interfaces for the input bytes and the decoded frames.
`default_nettype none

interface crc8fu_in_if;
	logic                  valid;
	logic                  ready;
	crc8fu_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface crc8fu_out_if;
	logic                  valid;
	logic                  ready;
	crc8fu_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/crc8_frame_unpacker_core.sv @@
// Top level of the CRC-8 frame unpacker: parser and registered result stage.
//
//  channel  | dir | payload                                  | handshake
//  in_ch    | in  | rx_byte, frame_start                     | valid/ready
//  out_ch   | out | address, opcode, length, value, crc, ok  | valid/ready
//
// One byte is taken per cycle while ready; a CRC byte gives a result in the next cycle.
// Input ready is low only while a result waits in the output register and out_ch.ready is low.
// Reset returns the parser to waiting for an address byte and empties the output register.
// Throughput is set by the single-byte CRC update between the parser state registers.
`default_nettype none

module crc8_frame_unpacker_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	crc8fu_in_if.sink    in_ch,
	crc8fu_out_if.source out_ch
);

	logic                   accept;
	logic                   out_valid_q;
	crc8fu_pkg::out_item_t  out_data_q;
	crc8fu_pkg::frame_evt_t evt;

	// Take a byte whenever the output register is empty or being emptied.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	crc8fu_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_ch.data),
		.evt    (evt)
	);

	// Result register: loaded by a completed frame, cleared by an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (evt.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.fire) begin
			out_data_q <= evt.res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

endmodule

`default_nettype wire

@@ sv/crc8fu_parser.sv @@
// Frame parser: phase tracking, running CRC and held header fields.
`default_nettype none

module crc8fu_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire crc8fu_pkg::in_item_t  item,
	output crc8fu_pkg::frame_evt_t     evt
);

	typedef enum logic [2:0] {
		PH_ADDR,
		PH_OPCODE,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_CRC
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  remaining_q, remaining_d;
	logic [7:0]  crc_q, crc_d;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  opcode_q, opcode_d;
	logic [7:0]  length_q, length_d;
	logic [15:0] last_two_q, last_two_d;
	logic [7:0]  crc_next;
	logic [7:0]  remaining_dec;

	assign crc_next      = crc8fu_pkg::crc8_update(crc_q, item.rx_byte);
	assign remaining_dec = remaining_q - 8'd1;

	// The result fields come straight from the held state; the CRC byte is compared here.
	always_comb begin
		evt.res.device_address = addr_q;
		evt.res.opcode         = opcode_q;
		evt.res.payload_length = length_q;
		evt.res.payload_value  = last_two_q;
		evt.res.crc_ok         = (crc_q == item.rx_byte);
		evt.res.computed_crc   = crc_q;
		evt.fire               = accept && !item.frame_start && (phase_q == PH_CRC);
	end

	// Next state for one accepted byte.
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		crc_d       = crc_q;
		addr_d      = addr_q;
		opcode_d    = opcode_q;
		length_d    = length_q;
		last_two_d  = last_two_q;
		if (item.frame_start || phase_q == PH_ADDR) begin
			// An address byte opens a new frame and drops any partial one.
			addr_d      = item.rx_byte;
			opcode_d    = '0;
			length_d    = '0;
			last_two_d  = '0;
			remaining_d = '0;
			crc_d       = crc8fu_pkg::crc8_update(crc8fu_pkg::CRC_INIT, item.rx_byte);
			phase_d     = PH_OPCODE;
		end else begin
			case (phase_q)
				PH_OPCODE: begin
					opcode_d = item.rx_byte;
					crc_d    = crc_next;
					phase_d  = PH_LENGTH;
				end
				PH_LENGTH: begin
					length_d    = item.rx_byte;
					remaining_d = item.rx_byte;
					last_two_d  = '0;
					crc_d       = crc_next;
					phase_d     = (item.rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					last_two_d  = {last_two_q[7:0], item.rx_byte};
					crc_d       = crc_next;
					remaining_d = remaining_dec;
					if (remaining_dec == 8'd0) begin
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					phase_d     = PH_ADDR;
					remaining_d = '0;
				end
				default: begin
					addr_d      = item.rx_byte;
					opcode_d    = '0;
					length_d    = '0;
					last_two_d  = '0;
					remaining_d = '0;
					crc_d       = crc8fu_pkg::crc8_update(crc8fu_pkg::CRC_INIT, item.rx_byte);
					phase_d     = PH_OPCODE;
				end
			endcase
		end
	end

	// State registers, updated on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ADDR;
			remaining_q <= '0;
			crc_q       <= '0;
			addr_q      <= '0;
			opcode_q    <= '0;
			length_q    <= '0;
			last_two_q  <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			crc_q       <= crc_d;
			addr_q      <= addr_d;
			opcode_q    <= opcode_d;
			length_q    <= length_d;
			last_two_q  <= last_two_d;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/crc8fu_frame_checker.sv @@
`timescale 1ns / 100ps
// Frame checker for the CRC-8 frame unpacker: predicts each decoded frame and compares results.
module crc8fu_frame_checker
	import crc8fu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	crc8fu_in_if      in_mon,
	crc8fu_out_if     out_mon,
	output int        fail_count,
	output int        outstanding
);

	// Parser phases of the predicted frame.
	typedef enum logic [2:0] {
		PH_ADDR,
		PH_OPCODE,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_CRC
	} phase_t;

	phase_t      phase;
	logic [7:0]  left_count;
	logic [7:0]  crc_acc;
	logic [7:0]  hdr_addr;
	logic [7:0]  hdr_op;
	logic [7:0]  hdr_len;
	logic [15:0] tail_bytes;
	out_item_t   frames_due[$];
	out_item_t   oldest;

	// One byte through the CRC register, one bit at a time from the top bit down.
	function automatic logic [7:0] crc8_advance(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			c = {c[6:0], 1'b0} ^ ((c[7] ^ b[i]) ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	// An address byte opens a fresh frame and drops whatever was held.
	task automatic start_frame(input logic [7:0] b);
		hdr_addr   = b;
		hdr_op     = '0;
		hdr_len    = '0;
		tail_bytes = '0;
		left_count = '0;
		crc_acc    = crc8_advance(CRC_INIT, b);
		phase      = PH_OPCODE;
	endtask

	// Advance the predicted parser by one accepted byte; the CRC byte yields a frame.
	task automatic predict_byte(input in_item_t it);
		out_item_t due;
		if (it.frame_start) begin
			start_frame(it.rx_byte);
		end else begin
			case (phase)
				PH_OPCODE: begin
					hdr_op  = it.rx_byte;
					crc_acc = crc8_advance(crc_acc, it.rx_byte);
					phase   = PH_LENGTH;
				end
				PH_LENGTH: begin
					hdr_len    = it.rx_byte;
					left_count = it.rx_byte;
					tail_bytes = '0;
					crc_acc    = crc8_advance(crc_acc, it.rx_byte);
					phase      = (it.rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					tail_bytes = {tail_bytes[7:0], it.rx_byte};
					crc_acc    = crc8_advance(crc_acc, it.rx_byte);
					left_count = left_count - 8'd1;
					if (left_count == 8'd0) begin
						phase = PH_CRC;
					end
				end
				PH_CRC: begin
					due.device_address = hdr_addr;
					due.opcode         = hdr_op;
					due.payload_length = hdr_len;
					due.payload_value  = tail_bytes;
					due.crc_ok         = (crc_acc == it.rx_byte);
					due.computed_crc   = crc_acc;
					frames_due.push_back(due);
					phase      = PH_ADDR;
					left_count = '0;
				end
				default: begin
					start_frame(it.rx_byte);
				end
			endcase
		end
	endtask

	task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Byte transfers feed the prediction; result transfers are checked against the oldest frame due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase      = PH_ADDR;
			left_count = '0;
			crc_acc    = CRC_INIT;
			hdr_addr   = '0;
			hdr_op     = '0;
			hdr_len    = '0;
			tail_bytes = '0;
			frames_due.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (in_mon.valid && in_mon.ready) begin
				predict_byte(in_mon.data);
			end
			if (out_mon.valid && out_mon.ready) begin
				if (frames_due.size() == 0) begin
					$error("result transfer with no frame due: address 0x%0h",
						out_mon.data.device_address);
					fail_count++;
				end else begin
					oldest = frames_due.pop_front();
					compare_field("device_address", 16'(oldest.device_address),
						16'(out_mon.data.device_address));
					compare_field("opcode", 16'(oldest.opcode), 16'(out_mon.data.opcode));
					compare_field("payload_length", 16'(oldest.payload_length),
						16'(out_mon.data.payload_length));
					compare_field("payload_value", oldest.payload_value,
						out_mon.data.payload_value);
					compare_field("crc_ok", 16'(oldest.crc_ok), 16'(out_mon.data.crc_ok));
					compare_field("computed_crc", 16'(oldest.computed_crc),
						16'(out_mon.data.computed_crc));
				end
			end
			outstanding <= frames_due.size();
		end
	end

endmodule

@@ tb/sv/tb_crc8_frame_unpacker_core.sv @@
`timescale 1ns / 100ps
// Testbench top for the CRC-8 frame unpacker: clock, reset, byte stimulus, back-pressure, verdict.
module tb_crc8_frame_unpacker_core;
	import crc8fu_pkg::*;

	localparam int         ITEM_TARGET = 450;
	localparam int         WHOLE_FRAME = 1024;
	localparam int         HOLD_CYCLES = 200;
	localparam int         QUIET_LIMIT = 2000;
	localparam logic [8:0] RANDOM_FILL = 9'h100;

	typedef enum logic {
		CRC_GOOD,
		CRC_BAD
	} crc_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   gaps_on = 1'b1;
	bit   stall_request = 1'b0;
	int   items_sent = 0;
	int   quiet_cycles = 0;
	int   fail_count;
	int   outstanding;

	crc8fu_in_if  in_ch ();
	crc8fu_out_if out_ch ();

	crc8_frame_unpacker_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	crc8fu_frame_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mon      (in_ch),
		.out_mon     (out_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// CRC of the bytes sent so far, used to close frames with a right or a wrong check byte.
	function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
		logic [8:0] acc;
		acc = {1'b0, crc ^ b};
		repeat (8) begin
			acc = {acc[7:0], 1'b0};
			if (acc[8]) begin
				acc = {1'b0, acc[7:0] ^ CRC_POLY};
			end
		end
		return acc[7:0];
	endfunction

	// Offer one byte, with random gaps when enabled, and hold it until the transfer happens.
	task automatic send_byte(input logic [7:0] b, input logic marker);
		while (gaps_on && $urandom_range(99) < 25) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= '{rx_byte: b, frame_start: marker};
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	// Send the first keep bytes of a frame; the payload is random or alternates fill and its inverse.
	task automatic send_frame(input logic marker, input logic [7:0] addr, input logic [7:0] op,
			input logic [7:0] len, input int keep, input crc_kind_t kind, input logic [8:0] fill);
		logic [7:0] crc;
		logic [7:0] b;
		int         total;
		total = int'(len) + 4;
		crc   = CRC_INIT;
		for (int n = 0; n < total && n < keep; n++) begin
			if (n == 0) begin
				b = addr;
			end else if (n == 1) begin
				b = op;
			end else if (n == 2) begin
				b = len;
			end else if (n == total - 1) begin
				b = (kind == CRC_BAD) ? crc ^ 8'($urandom_range(1, 255)) : crc;
			end else if (fill[8]) begin
				b = 8'($urandom);
			end else begin
				b = n[0] ? fill[7:0] : ~fill[7:0];
			end
			send_byte(b, marker && n == 0);
			crc = crc_next(crc, b);
		end
	endtask

	// Stop offering bytes until every frame due has been delivered.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Result side: random stalls, plus one long hold-off when the stimulus asks for it.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			out_ch.ready <= !gaps_on || ($urandom_range(99) >= 25);
		end
	end

	// Watchdog: too long without any transfer on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL crc8_frame_unpacker_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: directed frames, then a random mix of whole, broken and noisy traffic.
	initial begin
		logic [7:0] len;
		int         pick;
		bit         need_marker;
		bit         big_done;
		bit         stall_done;
		bit         drain_done;
		arst_n      <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty frame of zeros whose address carries no marker.
		send_frame(1'b0, 8'h00, 8'h00, 8'd0, WHOLE_FRAME, CRC_GOOD, 9'h000);
		// All ones with a single payload byte and a wrong check byte.
		send_frame(1'b1, 8'hFF, 8'hFF, 8'd1, WHOLE_FRAME, CRC_BAD, 9'h0FF);
		// Resynchronisation in the length phase, then a two-byte payload of 0x00 and 0xFF.
		send_frame(1'b1, 8'hAA, 8'h55, 8'd2, 2, CRC_GOOD, 9'h000);
		send_frame(1'b1, 8'hA5, 8'h5A, 8'd2, WHOLE_FRAME, CRC_GOOD, 9'h000);
		// Resynchronisation part way through the payload.
		send_frame(1'b1, 8'h12, 8'h34, 8'd3, 4, CRC_GOOD, RANDOM_FILL);
		send_frame(1'b1, 8'h80, 8'h01, 8'd0, WHOLE_FRAME, CRC_GOOD, 9'h000);
		// Frame cut off where its check byte is due.
		send_frame(1'b1, 8'h3C, 8'hC3, 8'd0, 3, CRC_GOOD, 9'h000);

		need_marker = 1'b1;
		big_done    = 1'b0;
		stall_done  = 1'b0;
		drain_done  = 1'b0;
		while (items_sent < ITEM_TARGET) begin
			gaps_on = !(items_sent >= 150 && items_sent < 250);
			if (!big_done && items_sent >= 60) begin
				// One frame of the longest payload.
				big_done = 1'b1;
				send_frame(1'b1, 8'($urandom), 8'($urandom), 8'd255, WHOLE_FRAME, CRC_GOOD,
					RANDOM_FILL);
				need_marker = 1'b0;
			end else if (!stall_done && items_sent >= 300) begin
				// Keep offering short frames while the result side holds off.
				stall_done    = 1'b1;
				stall_request = 1'b1;
				repeat (6) begin
					send_frame(1'b1, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 2)),
						WHOLE_FRAME, CRC_GOOD, RANDOM_FILL);
				end
				need_marker = 1'b0;
			end else if (!drain_done && items_sent >= 380) begin
				drain_done = 1'b1;
				drain();
			end else begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					// Whole frame, mostly short, now and then with a bad check byte.
					len = (pick < 8) ? 8'($urandom_range(7, 24)) : 8'($urandom_range(0, 6));
					send_frame(need_marker || $urandom_range(1), 8'($urandom), 8'($urandom), len,
						WHOLE_FRAME, ($urandom_range(3) == 0) ? CRC_BAD : CRC_GOOD,
						RANDOM_FILL);
					need_marker = 1'b0;
				end else if (pick < 90) begin
					// Frame cut short anywhere before its check byte.
					len = 8'($urandom_range(0, 6));
					send_frame(need_marker || $urandom_range(1), 8'($urandom), 8'($urandom), len,
						$urandom_range(1, int'(len) + 3), CRC_GOOD, RANDOM_FILL);
					need_marker = 1'b1;
				end else begin
					// A few stray bytes with random markers.
					repeat ($urandom_range(1, 4)) begin
						send_byte(8'($urandom), $urandom_range(3) == 0);
					end
					need_marker = 1'b1;
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS crc8_frame_unpacker_core");
		end else begin
			$display("FAIL crc8_frame_unpacker_core");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/crc8fu_pkg.sv
sv/crc8fu_if.sv
sv/crc8fu_parser.sv
sv/crc8_frame_unpacker_core.sv
tb/sv/crc8fu_frame_checker.sv
tb/sv/tb_crc8_frame_unpacker_core.sv
